### rtl/segment_intersection_unit_defines.svh
// assertion macros shared by the segment intersection checkers
`ifndef SEGMENT_INTERSECTION_UNIT_DEFINES_SVH
`define SEGMENT_INTERSECTION_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define SEGINT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define SEGINT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define SEGINT_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/segint_pkg.sv
// shared constants for the segment intersection unit
package segint_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

endpackage

### rtl/segment_intersection_unit.sv
// throughput: one segment pair per cycle while no stalled result holds the pipe;
// 4 arithmetic stages, then a restoring divider that retires one quotient bit per
// stage for x and y in parallel
// a stalled result holds the whole pipe only when the last divider stage is full
// reset (rst_n low, synchronous) clears all valid bits; data registers are not reset
module segment_intersection_unit
  import segint_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_BITS-1:0]          in_start1_x,
  input  logic signed [COORD_BITS-1:0]          in_start1_y,
  input  logic signed [COORD_BITS-1:0]          in_end1_x,
  input  logic signed [COORD_BITS-1:0]          in_end1_y,
  input  logic signed [COORD_BITS-1:0]          in_start2_x,
  input  logic signed [COORD_BITS-1:0]          in_start2_y,
  input  logic signed [COORD_BITS-1:0]          in_end2_x,
  input  logic signed [COORD_BITS-1:0]          in_end2_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_hit,
  output logic signed [COORD_BITS+FRAC_BITS-1:0] out_cross_x,
  output logic signed [COORD_BITS+FRAC_BITS-1:0] out_cross_y
);

  localparam int DW = COORD_BITS + 1;        // coordinate differences
  localparam int PW = 2 * COORD_BITS + 2;    // products and cross terms
  localparam int MW = 2 * COORD_BITS + 1;    // magnitude of a cross term
  localparam int QB = COORD_BITS + FRAC_BITS; // quotient and result width
  localparam int NW = MW + COORD_BITS;       // |t_numer| * |d1|

  typedef struct packed {
    logic                         hit;
    logic                         neg_x;
    logic                         neg_y;
    logic signed [COORD_BITS-1:0] s1_x;
    logic signed [COORD_BITS-1:0] s1_y;
    logic [MW-1:0]                den_mag;
  } ctx_t;

  logic en;
  logic load;
  logic v_last;

  // ---------------- stage 1: differences
  logic                         st1_v_r;
  logic signed [DW-1:0]         st1_d1x_r, st1_d1y_r, st1_d2x_r, st1_d2y_r;
  logic signed [DW-1:0]         st1_ax_r, st1_ay_r;
  logic signed [COORD_BITS-1:0] st1_s1x_r, st1_s1y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
    end else if (en) begin
      st1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_d1x_r <= DW'(in_end1_x) - DW'(in_start1_x);
      st1_d1y_r <= DW'(in_end1_y) - DW'(in_start1_y);
      st1_d2x_r <= DW'(in_end2_x) - DW'(in_start2_x);
      st1_d2y_r <= DW'(in_end2_y) - DW'(in_start2_y);
      st1_ax_r  <= DW'(in_start1_x) - DW'(in_start2_x);
      st1_ay_r  <= DW'(in_start1_y) - DW'(in_start2_y);
      st1_s1x_r <= in_start1_x;
      st1_s1y_r <= in_start1_y;
    end
  end

  // ---------------- stage 2: six products
  logic                         st2_v_r;
  logic signed [PW-1:0]         st2_pd1_r, st2_pd2_r, st2_ps1_r, st2_ps2_r;
  logic signed [PW-1:0]         st2_pt1_r, st2_pt2_r;
  logic signed [DW-1:0]         st2_d1x_r, st2_d1y_r;
  logic signed [COORD_BITS-1:0] st2_s1x_r, st2_s1y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st2_v_r <= 1'b0;
    end else if (en) begin
      st2_v_r <= st1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2_pd1_r <= PW'(st1_d1x_r) * PW'(st1_d2y_r);
      st2_pd2_r <= PW'(st1_d2x_r) * PW'(st1_d1y_r);
      st2_ps1_r <= PW'(st1_d1x_r) * PW'(st1_ay_r);
      st2_ps2_r <= PW'(st1_d1y_r) * PW'(st1_ax_r);
      st2_pt1_r <= PW'(st1_d2x_r) * PW'(st1_ay_r);
      st2_pt2_r <= PW'(st1_d2y_r) * PW'(st1_ax_r);
      st2_d1x_r <= st1_d1x_r;
      st2_d1y_r <= st1_d1y_r;
      st2_s1x_r <= st1_s1x_r;
      st2_s1y_r <= st1_s1y_r;
    end
  end

  // ---------------- stage 3: denominator and numerators
  logic                         st3_v_r;
  logic signed [PW-1:0]         st3_den_r, st3_sn_r, st3_tn_r;
  logic signed [DW-1:0]         st3_d1x_r, st3_d1y_r;
  logic signed [COORD_BITS-1:0] st3_s1x_r, st3_s1y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st3_v_r <= 1'b0;
    end else if (en) begin
      st3_v_r <= st2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st3_den_r <= st2_pd1_r - st2_pd2_r;
      st3_sn_r  <= st2_ps1_r - st2_ps2_r;
      st3_tn_r  <= st2_pt1_r - st2_pt2_r;
      st3_d1x_r <= st2_d1x_r;
      st3_d1y_r <= st2_d1y_r;
      st3_s1x_r <= st2_s1x_r;
      st3_s1y_r <= st2_s1y_r;
    end
  end

  // ---------------- stage 4: hit tests, signs and magnitudes
  logic                  st4_v_r;
  ctx_t                  st4_ctx_r;
  logic [MW-1:0]         st4_tmag_r;
  logic [COORD_BITS-1:0] st4_d1xmag_r, st4_d1ymag_r;

  logic          pos_nxt;
  logic          miss_nxt;
  logic [PW-1:0] den_abs_nxt, tn_abs_nxt;
  logic [DW-1:0] d1x_abs_nxt, d1y_abs_nxt;
  ctx_t          ctx_nxt;

  always_comb begin
    pos_nxt  = !st3_den_r[PW-1] && (st3_den_r != '0);
    // sign and range tests kept as given, boundaries differ for negative denominators
    miss_nxt = (st3_den_r == '0) ||
               (st3_sn_r[PW-1] == pos_nxt) ||
               (st3_tn_r[PW-1] == pos_nxt) ||
               ((st3_sn_r > st3_den_r) == pos_nxt) ||
               ((st3_tn_r > st3_den_r) == pos_nxt);
    den_abs_nxt = st3_den_r[PW-1] ? PW'(-st3_den_r) : PW'(st3_den_r);
    tn_abs_nxt  = st3_tn_r[PW-1]  ? PW'(-st3_tn_r)  : PW'(st3_tn_r);
    d1x_abs_nxt = st3_d1x_r[DW-1] ? DW'(-st3_d1x_r) : DW'(st3_d1x_r);
    d1y_abs_nxt = st3_d1y_r[DW-1] ? DW'(-st3_d1y_r) : DW'(st3_d1y_r);
    ctx_nxt.hit     = !miss_nxt;
    ctx_nxt.neg_x   = st3_tn_r[PW-1] ^ st3_d1x_r[DW-1] ^ st3_den_r[PW-1];
    ctx_nxt.neg_y   = st3_tn_r[PW-1] ^ st3_d1y_r[DW-1] ^ st3_den_r[PW-1];
    ctx_nxt.s1_x    = st3_s1x_r;
    ctx_nxt.s1_y    = st3_s1y_r;
    ctx_nxt.den_mag = den_abs_nxt[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st4_v_r <= 1'b0;
    end else if (en) begin
      st4_v_r <= st3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st4_ctx_r    <= ctx_nxt;
      st4_tmag_r   <= tn_abs_nxt[MW-1:0];
      st4_d1xmag_r <= d1x_abs_nxt[COORD_BITS-1:0];
      st4_d1ymag_r <= d1y_abs_nxt[COORD_BITS-1:0];
    end
  end

  // ---------------- divider: entry 0 holds the dividend, then one quotient bit per stage
  logic [QB:0]   dv_v_r;
  ctx_t          dv_ctx_r  [QB+1];
  logic [QB-1:0] dv_quox_r [QB+1];
  logic [QB-1:0] dv_quoy_r [QB+1];
  logic [MW-1:0] dv_remx_r [QB];
  logic [MW-1:0] dv_remy_r [QB];
  logic [QB-1:0] dv_lowx_r [QB];
  logic [QB-1:0] dv_lowy_r [QB];

  logic [NW-1:0] px_nxt, py_nxt;

  assign px_nxt = NW'(st4_tmag_r) * NW'(st4_d1xmag_r);
  assign py_nxt = NW'(st4_tmag_r) * NW'(st4_d1ymag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= st4_v_r;
    end
  end

  // the high part of the dividend is below the divisor on a hit, so it preloads the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      dv_ctx_r[0]  <= st4_ctx_r;
      dv_quox_r[0] <= '0;
      dv_quoy_r[0] <= '0;
      dv_remx_r[0] <= px_nxt[NW-1:COORD_BITS];
      dv_remy_r[0] <= py_nxt[NW-1:COORD_BITS];
      dv_lowx_r[0] <= QB'(px_nxt[COORD_BITS-1:0]) << FRAC_BITS;
      dv_lowy_r[0] <= QB'(py_nxt[COORD_BITS-1:0]) << FRAC_BITS;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [MW:0] dext;
    logic [MW:0] tx, ty;
    logic        gex, gey;

    always_comb begin
      dext = {1'b0, dv_ctx_r[k-1].den_mag};
      tx   = {dv_remx_r[k-1], dv_lowx_r[k-1][QB-1]};
      ty   = {dv_remy_r[k-1], dv_lowy_r[k-1][QB-1]};
      gex  = tx >= dext;
      gey  = ty >= dext;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (en) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_ctx_r[k]  <= dv_ctx_r[k-1];
        dv_quox_r[k] <= {dv_quox_r[k-1][QB-2:0], gex};
        dv_quoy_r[k] <= {dv_quoy_r[k-1][QB-2:0], gey};
      end
    end

    if (k < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          dv_remx_r[k] <= gex ? MW'(tx - dext) : MW'(tx);
          dv_remy_r[k] <= gey ? MW'(ty - dext) : MW'(ty);
          dv_lowx_r[k] <= dv_lowx_r[k-1] << 1;
          dv_lowy_r[k] <= dv_lowy_r[k-1] << 1;
        end
      end
    end
  end

  // ---------------- result: apply sign, add start point, zero on a miss
  ctx_t          lst_ctx;
  logic [QB-1:0] offx_nxt, offy_nxt;
  logic [QB-1:0] basex_nxt, basey_nxt;
  logic [QB-1:0] crossx_nxt, crossy_nxt;

  always_comb begin
    lst_ctx    = dv_ctx_r[QB];
    offx_nxt   = lst_ctx.neg_x ? QB'(-dv_quox_r[QB]) : dv_quox_r[QB];
    offy_nxt   = lst_ctx.neg_y ? QB'(-dv_quoy_r[QB]) : dv_quoy_r[QB];
    basex_nxt  = QB'(lst_ctx.s1_x) << FRAC_BITS;
    basey_nxt  = QB'(lst_ctx.s1_y) << FRAC_BITS;
    crossx_nxt = lst_ctx.hit ? QB'(basex_nxt + offx_nxt) : '0;
    crossy_nxt = lst_ctx.hit ? QB'(basey_nxt + offy_nxt) : '0;
  end

  logic          out_valid_r;
  logic          out_hit_r;
  logic [QB-1:0] out_cross_x_r, out_cross_y_r;

  // the pipe keeps moving while the last stage holds a bubble, even with a beat waiting
  assign v_last   = dv_v_r[QB];
  assign load     = out_ready || !out_valid_r;
  assign en       = load || !v_last;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= v_last;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_hit_r     <= lst_ctx.hit;
      out_cross_x_r <= crossx_nxt;
      out_cross_y_r <= crossy_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_cross_x = out_cross_x_r;
  assign out_cross_y = out_cross_y_r;

endmodule

### rtl/segint_checker.sv
// port-level checks for the segment intersection unit, bound to the top level
`include "segment_intersection_unit_defines.svh"

module segint_checker
  import segint_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  out_hit,
  input logic signed [COORD_BITS+FRAC_BITS-1:0] out_cross_x,
  input logic signed [COORD_BITS+FRAC_BITS-1:0] out_cross_y
);

  // a waiting result beat keeps its value
  `SEGINT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hit) && $stable(out_cross_x) && $stable(out_cross_y), "result beat changed while stalled")

  // a miss carries a zero point
  `SEGINT_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, out_cross_x == '0 && out_cross_y == '0, "miss with nonzero point")

  // with no beat waiting at the output the pipe never stalls
  `SEGINT_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input stalled with empty output")

  // reset empties the output
  `SEGINT_ASSERT_ALWAYS(a_rst_empty, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind segment_intersection_unit segint_checker #(
  .COORD_BITS(COORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_segint_checker (.*);

### tb/sv/segint_result_checker.sv
// result checker for the segment intersection unit: predicts every result beat and compares it
module segint_result_checker
  import segint_pkg::*;
(
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  input  logic                                           in_ready,
  input  logic signed [COORD_BITS_DEF-1:0]               in_start1_x,
  input  logic signed [COORD_BITS_DEF-1:0]               in_start1_y,
  input  logic signed [COORD_BITS_DEF-1:0]               in_end1_x,
  input  logic signed [COORD_BITS_DEF-1:0]               in_end1_y,
  input  logic signed [COORD_BITS_DEF-1:0]               in_start2_x,
  input  logic signed [COORD_BITS_DEF-1:0]               in_start2_y,
  input  logic signed [COORD_BITS_DEF-1:0]               in_end2_x,
  input  logic signed [COORD_BITS_DEF-1:0]               in_end2_y,
  input  logic                                           out_valid,
  input  logic                                           out_ready,
  input  logic                                           out_hit,
  input  logic signed [COORD_BITS_DEF+FRAC_BITS_DEF-1:0] out_cross_x,
  input  logic signed [COORD_BITS_DEF+FRAC_BITS_DEF-1:0] out_cross_y,
  output int                                             fail_count,
  output int                                             open_count
);

  localparam int CW = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int OW = CW + FB;

  typedef struct {
    logic                 hit;
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
  } crossing_t;

  crossing_t crossing_q[$];

  function automatic bit [63:0] magnitude(input longint v);
    bit [63:0] u;
    u = v;
    return (v < 0) ? -u : u;
  endfunction

  // start coordinate plus the truncated fraction of the segment delta, in fixed point
  function automatic logic signed [OW-1:0] fixed_point_coord(input longint base,
                                                             input longint delta,
                                                             input longint tn,
                                                             input longint den);
    bit [63:0] num;
    bit [63:0] quo;
    bit [63:0] ubase;
    bit [63:0] sum;
    bit        neg;
    num   = (magnitude(tn) * magnitude(delta)) << FB;
    quo   = num / magnitude(den);
    neg   = ((tn < 0) != (delta < 0)) != (den < 0);
    ubase = base;
    sum   = (ubase << FB) + (neg ? -quo : quo);
    return sum[OW-1:0];
  endfunction

  function automatic crossing_t predict_crossing(input logic signed [CW-1:0] p1x, p1y,
                                                 input logic signed [CW-1:0] q1x, q1y,
                                                 input logic signed [CW-1:0] p2x, p2y,
                                                 input logic signed [CW-1:0] q2x, q2y);
    longint    d1x, d1y, d2x, d2y, ax, ay;
    longint    den, sn, tn;
    bit        pos;
    bit        hit;
    crossing_t c;
    d1x = longint'(q1x) - longint'(p1x);
    d1y = longint'(q1y) - longint'(p1y);
    d2x = longint'(q2x) - longint'(p2x);
    d2y = longint'(q2y) - longint'(p2y);
    ax  = longint'(p1x) - longint'(p2x);
    ay  = longint'(p1y) - longint'(p2y);
    den = d1x * d2y - d2x * d1y;
    sn  = d1x * ay - d1y * ax;
    tn  = d2x * ay - d2y * ax;
    pos = den > 0;
    // boundary tests kept as-is: a negative denominator treats the ends differently
    if (den == 0) begin
      hit = 1'b0;
    end else if ((sn < 0) == pos) begin
      hit = 1'b0;
    end else if ((tn < 0) == pos) begin
      hit = 1'b0;
    end else if (((sn > den) == pos) || ((tn > den) == pos)) begin
      hit = 1'b0;
    end else begin
      hit = 1'b1;
    end
    c.hit = hit;
    c.x   = hit ? fixed_point_coord(longint'(p1x), d1x, tn, den) : '0;
    c.y   = hit ? fixed_point_coord(longint'(p1y), d1y, tn, den) : '0;
    return c;
  endfunction

  initial begin
    fail_count = 0;
    open_count = 0;
  end

  always @(posedge clk) begin : watch_beats
    crossing_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        crossing_q.push_back(predict_crossing(in_start1_x, in_start1_y, in_end1_x, in_end1_y,
                                              in_start2_x, in_start2_y, in_end2_x, in_end2_y));
      end
      if (out_valid && out_ready) begin
        if (crossing_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected: hit=%0b x=%0d y=%0d",
                   $time, out_hit, out_cross_x, out_cross_y);
        end else begin
          want = crossing_q.pop_front();
          if (out_hit !== want.hit || out_cross_x !== want.x || out_cross_y !== want.y) begin
            fail_count++;
            $display("%0t: mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                     $time, want.hit, want.x, want.y, out_hit, out_cross_x, out_cross_y);
          end
        end
      end
      open_count = crossing_q.size();
    end
  end

endmodule

### tb/sv/tb.sv
// testbench top for the segment intersection unit: drives segment pairs and gives the verdict
module tb;
  import segint_pkg::*;

  localparam int CW           = COORD_BITS_DEF;
  localparam int FB           = FRAC_BITS_DEF;
  localparam int OW           = CW + FB;
  localparam int LATENCY      = CW + FB + 6;
  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_PAIRS = 2000;

  typedef struct {
    logic signed [CW-1:0] s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
  } seg_pair_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [CW-1:0] in_start1_x = '0;
  logic signed [CW-1:0] in_start1_y = '0;
  logic signed [CW-1:0] in_end1_x = '0;
  logic signed [CW-1:0] in_end1_y = '0;
  logic signed [CW-1:0] in_start2_x = '0;
  logic signed [CW-1:0] in_start2_y = '0;
  logic signed [CW-1:0] in_end2_x = '0;
  logic signed [CW-1:0] in_end2_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_hit;
  logic signed [OW-1:0] out_cross_x;
  logic signed [OW-1:0] out_cross_y;

  int        fail_count;
  int        open_count;
  int        src_idle_pct = 10;
  int        sink_stall_pct = 53;
  seg_pair_t directed[$];

  segment_intersection_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_start1_x(in_start1_x),
    .in_start1_y(in_start1_y),
    .in_end1_x  (in_end1_x),
    .in_end1_y  (in_end1_y),
    .in_start2_x(in_start2_x),
    .in_start2_y(in_start2_y),
    .in_end2_x  (in_end2_x),
    .in_end2_y  (in_end2_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit),
    .out_cross_x(out_cross_x),
    .out_cross_y(out_cross_y)
  );

  segint_result_checker crossing_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_start1_x(in_start1_x),
    .in_start1_y(in_start1_y),
    .in_end1_x  (in_end1_x),
    .in_end1_y  (in_end1_y),
    .in_start2_x(in_start2_x),
    .in_start2_y(in_start2_y),
    .in_end2_x  (in_end2_x),
    .in_end2_y  (in_end2_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit),
    .out_cross_x(out_cross_x),
    .out_cross_y(out_cross_y),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= (int'($urandom_range(99)) >= sink_stall_pct);
  end

  // ends the run once nothing has moved on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  function automatic seg_pair_t pair_of(input int a, b, c, d, e, f, g, h);
    seg_pair_t p;
    p.s1x = CW'(a);
    p.s1y = CW'(b);
    p.e1x = CW'(c);
    p.e1y = CW'(d);
    p.s2x = CW'(e);
    p.s2y = CW'(f);
    p.e2x = CW'(g);
    p.e2y = CW'(h);
    return p;
  endfunction

  function automatic int near_origin();
    return int'($urandom_range(12)) - 6;
  endfunction

  function automatic int pick_extreme();
    int vals[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    return vals[$urandom_range(6)];
  endfunction

  function automatic seg_pair_t random_pair();
    int        kind, cx, cy, ux, uy, vx, vy, k1, k2;
    int        sx, sy, dx, dy, t, r;
    seg_pair_t p;
    kind = $urandom_range(99);
    if (kind < 30) begin
      p = pair_of($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 55) begin
      // tiny grid: touching ends, degenerate and parallel cases come up often
      p = pair_of(near_origin(), near_origin(), near_origin(), near_origin(),
                  near_origin(), near_origin(), near_origin(), near_origin());
    end else if (kind < 80) begin
      // two segments built through a common point, with a little jitter
      cx = int'($urandom_range(32000)) - 16000;
      cy = int'($urandom_range(32000)) - 16000;
      ux = int'($urandom_range(32000)) - 16000;
      uy = int'($urandom_range(32000)) - 16000;
      vx = int'($urandom_range(32000)) - 16000;
      vy = int'($urandom_range(32000)) - 16000;
      k1 = $urandom_range(1, 16);
      k2 = $urandom_range(1, 16);
      p = pair_of(cx - ux, cy - uy, cx + ux * k1 / 16, cy + uy * k1 / 16,
                  cx - vx, cy - vy, cx + vx * k2 / 16 + int'($urandom_range(2)) - 1,
                  cy + vy * k2 / 16);
    end else if (kind < 90) begin
      // parallel or collinear pairs
      sx = int'($urandom_range(2000)) - 1000;
      sy = int'($urandom_range(2000)) - 1000;
      dx = int'($urandom_range(2000)) - 1000 - sx;
      dy = int'($urandom_range(2000)) - 1000 - sy;
      r  = $urandom_range(1) ? 1 : -1;
      if ($urandom_range(1)) begin
        t = int'($urandom_range(2)) - 1;
        p = pair_of(sx, sy, sx + dx, sy + dy,
                    sx + dx * t, sy + dy * t, sx + dx * t + dx * r, sy + dy * t + dy * r);
      end else begin
        cx = int'($urandom_range(20)) - 10;
        cy = int'($urandom_range(20)) - 10;
        p = pair_of(sx, sy, sx + dx, sy + dy,
                    sx + cx, sy + cy, sx + cx + dx * r, sy + cy + dy * r);
      end
    end else begin
      p = pair_of(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                  pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
    end
    return p;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_pair(input seg_pair_t p);
    while (int'($urandom_range(99)) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_start1_x <= p.s1x;
    in_start1_y <= p.s1y;
    in_end1_x   <= p.e1x;
    in_end1_y   <= p.e1y;
    in_start2_x <= p.s2x;
    in_start2_y <= p.s2y;
    in_end2_x   <= p.e2x;
    in_end2_y   <= p.e2y;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (open_count != 0);
  endtask

  initial begin
    // crossings with both denominator signs, end touches, parallel and extreme coordinates
    directed.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(pair_of(0, 0, 10, 10, 0, 10, 10, 0));
    directed.push_back(pair_of(0, 10, 10, 0, 0, 0, 10, 10));
    directed.push_back(pair_of(0, 0, 10, 0, 0, 5, 10, 5));
    directed.push_back(pair_of(0, 0, 10, 0, 5, 0, 15, 0));
    directed.push_back(pair_of(0, 0, 10, 0, 0, -5, 0, 5));
    directed.push_back(pair_of(0, 0, 10, 0, 0, 5, 0, -5));
    directed.push_back(pair_of(0, 0, 10, 0, 10, -5, 10, 5));
    directed.push_back(pair_of(0, 0, 10, 0, 10, 5, 10, -5));
    directed.push_back(pair_of(-5, 0, 5, 0, 0, 0, 0, 5));
    directed.push_back(pair_of(5, 0, -5, 0, 0, 0, 0, 5));
    directed.push_back(pair_of(-5, 0, 5, 0, 0, -5, 0, 0));
    directed.push_back(pair_of(5, 0, -5, 0, 0, -5, 0, 0));
    directed.push_back(pair_of(0, 0, 10, 0, 20, -5, 20, 5));
    directed.push_back(pair_of(0, 0, 10, 10, 0, 10, 2, 8));
    directed.push_back(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    directed.push_back(pair_of(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
    directed.push_back(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    directed.push_back(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    directed.push_back(pair_of(0, 0, 3, 7, 1, 0, 0, 5));
    directed.push_back(pair_of(0, 0, -3, 7, -1, 0, 0, 5));
    directed.push_back(pair_of(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));

    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_pair(directed[i]);
    // sender holds off until the pipe is empty
    wait_for_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 10;
          sink_stall_pct = 53;
        end
        1: begin
          src_idle_pct   = 53;
          sink_stall_pct = 10;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PAIRS / 3; n++) send_pair(random_pair());
      wait_for_results();
    end

    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
